// File: hw/rtl/stw_pkg.sv
`default_nettype none

package stw_pkg;

    // table size and default number of usable entries
    localparam int MAX_SPRITES_DEF = 64;
    localparam int TABLE_DEPTH     = 64;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 7;
    localparam int CMD_W   = 3;

    // request codes
    localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HIDE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HIDE_ALL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GRP_BEGIN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GRP_ENTRY = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

    // result kinds
    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_GROUP = 1'b1;

    // special byte values
    localparam logic [BYTE_W-1:0] HIDDEN_Y = 8'hFF;
    localparam logic [BYTE_W-1:0] END_MARK = 8'h80;

    // queue depths
    localparam int OPQ_DEPTH  = 2;
    localparam int RESQ_DEPTH = 2;

    // operations handed from front to back
    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_HIDE     = 3'd1,
        OP_HIDE_ALL = 3'd2,
        OP_READ     = 3'd3,
        OP_REPORT   = 3'd4
    } op_code_t;

    typedef struct packed {
        op_code_t              code;
        logic [SLOT_W-1:0]     slot;
        logic                  in_range;
        logic [BYTE_W-1:0]     y;
        logic [BYTE_W-1:0]     tile;
        logic [BYTE_W-1:0]     attr;
        logic [BYTE_W-1:0]     x;
        logic [SLOT_W-1:0]     count;
    } op_t;

    typedef struct packed {
        logic                  kind;
        logic [BYTE_W-1:0]     y;
        logic [BYTE_W-1:0]     tile;
        logic [BYTE_W-1:0]     attr;
        logic [BYTE_W-1:0]     x;
        logic [SLOT_W-1:0]     count;
    } res_t;

    // generic attribute to packed hardware attribute
    function automatic logic [BYTE_W-1:0] map_attr(input logic [BYTE_W-1:0] a);
        map_attr = {a[1], a[0], a[2], 3'b000, a[5:4]};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stw_ram.sv
`default_nettype none

module stw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]     wdata,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stw_front.sv
`default_nettype none

module stw_front #(
    parameter int MAX_SPRITES = stw_pkg::MAX_SPRITES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire logic                        full,
    input  wire logic [stw_pkg::CMD_W-1:0]   cmd,
    input  wire logic [5:0]                  slot,
    input  wire logic [15:0]                 pos_x,
    input  wire logic [15:0]                 pos_y,
    input  wire logic [7:0]                  tile,
    input  wire logic [7:0]                  attr,
    input  wire logic signed [7:0]           offset_x,
    input  wire logic signed [7:0]           offset_y,
    input  wire logic [7:0]                  attr_xor,
    output logic                             op_push,
    output stw_pkg::op_t                     op
);

    localparam logic [stw_pkg::SLOT_W-1:0] MAX_SLOT = stw_pkg::SLOT_W'(MAX_SPRITES);

    // group state, only the integer bytes of the base position matter
    logic [stw_pkg::SLOT_W-1:0] grp_slot_reg, grp_slot_next;
    logic [stw_pkg::SLOT_W-1:0] grp_start_reg, grp_start_next;
    logic [7:0]                 grp_x_reg, grp_x_next;
    logic [7:0]                 grp_y_reg, grp_y_next;
    logic [7:0]                 grp_attr_reg, grp_attr_next;

    logic                       accept;
    logic                       slot_ok;
    logic [7:0]                 off_x_u;
    logic [7:0]                 off_y_u;

    assign accept  = push && !full;
    assign slot_ok = {1'b0, slot} < MAX_SLOT;
    assign off_x_u = $unsigned(offset_x);
    assign off_y_u = $unsigned(offset_y);

    // decode request into a back-end operation
    always_comb
    begin
        op             = '0;
        op_push        = 1'b0;
        grp_slot_next  = grp_slot_reg;
        grp_start_next = grp_start_reg;
        grp_x_next     = grp_x_reg;
        grp_y_next     = grp_y_reg;
        grp_attr_next  = grp_attr_reg;
        op.slot        = {1'b0, slot};
        op.in_range    = slot_ok;
        if (accept)
        begin
            case (cmd)
                stw_pkg::CMD_SET:
                begin
                    op.code = stw_pkg::OP_WRITE;
                    op.y    = 8'(pos_y[15:8] - 8'd1);
                    op.tile = tile;
                    op.attr = stw_pkg::map_attr(attr);
                    op.x    = pos_x[15:8];
                    op_push = slot_ok;
                end
                stw_pkg::CMD_HIDE:
                begin
                    op.code = stw_pkg::OP_HIDE;
                    op_push = slot_ok;
                end
                stw_pkg::CMD_HIDE_ALL:
                begin
                    op.code = stw_pkg::OP_HIDE_ALL;
                    op_push = 1'b1;
                end
                stw_pkg::CMD_GRP_BEGIN:
                begin
                    grp_start_next = {1'b0, slot};
                    grp_slot_next  = {1'b0, slot};
                    grp_x_next     = pos_x[15:8];
                    grp_y_next     = pos_y[15:8];
                    grp_attr_next  = attr;
                end
                stw_pkg::CMD_GRP_ENTRY:
                begin
                    if (off_x_u == stw_pkg::END_MARK)
                    begin
                        op.code  = stw_pkg::OP_REPORT;
                        op.count = stw_pkg::SLOT_W'(grp_slot_reg - grp_start_reg);
                        op_push  = 1'b1;
                    end
                    else if (grp_slot_reg < MAX_SLOT)
                    begin
                        op.code       = stw_pkg::OP_WRITE;
                        op.slot       = grp_slot_reg;
                        op.in_range   = 1'b1;
                        op.y          = 8'(grp_y_reg + off_y_u - 8'd1);
                        op.tile       = tile;
                        op.attr       = stw_pkg::map_attr(grp_attr_reg ^ attr_xor);
                        op.x          = 8'(grp_x_reg + off_x_u);
                        op_push       = 1'b1;
                        grp_slot_next = stw_pkg::SLOT_W'(grp_slot_reg + 1'b1);
                    end
                end
                stw_pkg::CMD_READ:
                begin
                    op.code = stw_pkg::OP_READ;
                    op_push = 1'b1;
                end
                default:
                begin
                    op_push = 1'b0;
                end
            endcase
        end
    end

    // group state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_slot_reg  <= '0;
            grp_start_reg <= '0;
            grp_x_reg     <= '0;
            grp_y_reg     <= '0;
            grp_attr_reg  <= '0;
        end
        else
        begin
            grp_slot_reg  <= grp_slot_next;
            grp_start_reg <= grp_start_next;
            grp_x_reg     <= grp_x_next;
            grp_y_reg     <= grp_y_next;
            grp_attr_reg  <= grp_attr_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stw_op_fifo.sv
`default_nettype none

module stw_op_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire stw_pkg::op_t  din,
    output logic               full,
    input  wire logic          pop,
    output stw_pkg::op_t       dout,
    output logic               empty
);

    localparam int PW = (stw_pkg::OPQ_DEPTH > 1) ? $clog2(stw_pkg::OPQ_DEPTH) : 1;
    localparam int CW = $clog2(stw_pkg::OPQ_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(stw_pkg::OPQ_DEPTH - 1);

    stw_pkg::op_t   q_reg [stw_pkg::OPQ_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push;
    logic           do_pop;

    assign full    = cnt_reg == CW'(stw_pkg::OPQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = q_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stw_back.sv
`default_nettype none

module stw_back #(
    parameter int MAX_SPRITES = stw_pkg::MAX_SPRITES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           op_empty,
    input  wire stw_pkg::op_t   op,
    output logic                op_pop,
    output logic                empty,
    input  wire logic           pop,
    output stw_pkg::res_t       res
);

    localparam int AW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SPRITES - 1);
    localparam int RPW = (stw_pkg::RESQ_DEPTH > 1) ? $clog2(stw_pkg::RESQ_DEPTH) : 1;
    localparam int RCW = $clog2(stw_pkg::RESQ_DEPTH + 1);
    localparam logic [RPW-1:0] RLAST = RPW'(stw_pkg::RESQ_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      sweep_reg, sweep_next;

    // ram ports
    logic               y_we;
    logic               r_we;
    logic [AW-1:0]      ram_addr;
    logic [7:0]         y_wdata;
    logic [23:0]        r_wdata;
    logic [7:0]         y_rdata;
    logic [23:0]        r_rdata;

    // result waiting for ram data
    logic                           pend_valid_reg, pend_valid_next;
    logic                           pend_kind_reg, pend_kind_next;
    logic                           pend_rd_reg, pend_rd_next;
    logic [stw_pkg::SLOT_W-1:0]     pend_count_reg, pend_count_next;

    // result queue
    stw_pkg::res_t      rq_reg [stw_pkg::RESQ_DEPTH];
    logic [RPW-1:0]     rq_wr_reg, rq_wr_next;
    logic [RPW-1:0]     rq_rd_reg, rq_rd_next;
    logic [RCW-1:0]     rq_cnt_reg, rq_cnt_next;
    logic               rq_pop;
    logic               res_room;
    stw_pkg::res_t      res_in;

    assign res_room = ({1'b0, rq_cnt_reg} + (RCW + 1)'(pend_valid_reg))
                      < (RCW + 1)'(stw_pkg::RESQ_DEPTH);

    // operation sequencer
    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        op_pop          = 1'b0;
        y_we            = 1'b0;
        r_we            = 1'b0;
        ram_addr        = op.slot[AW-1:0];
        y_wdata         = op.y;
        r_wdata         = {op.x, op.attr, op.tile};
        pend_valid_next = 1'b0;
        pend_kind_next  = pend_kind_reg;
        pend_rd_next    = pend_rd_reg;
        pend_count_next = pend_count_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (!op_empty)
                begin
                    case (op.code)
                        stw_pkg::OP_WRITE:
                        begin
                            y_we   = 1'b1;
                            r_we   = 1'b1;
                            op_pop = 1'b1;
                        end
                        stw_pkg::OP_HIDE:
                        begin
                            y_we    = 1'b1;
                            y_wdata = stw_pkg::HIDDEN_Y;
                            op_pop  = 1'b1;
                        end
                        stw_pkg::OP_HIDE_ALL:
                        begin
                            op_pop     = 1'b1;
                            sweep_next = '0;
                            state_next = ST_SWEEP;
                        end
                        stw_pkg::OP_READ,
                        stw_pkg::OP_REPORT:
                        begin
                            if (res_room)
                            begin
                                op_pop          = 1'b1;
                                pend_valid_next = 1'b1;
                                pend_kind_next  = (op.code == stw_pkg::OP_REPORT)
                                                  ? stw_pkg::KIND_GROUP
                                                  : stw_pkg::KIND_ENTRY;
                                pend_rd_next    = (op.code == stw_pkg::OP_READ)
                                                  && op.in_range;
                                pend_count_next = (op.code == stw_pkg::OP_REPORT)
                                                  ? op.count : '0;
                            end
                        end
                        default:
                        begin
                            op_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                ram_addr = sweep_reg;
                y_we     = 1'b1;
                y_wdata  = stw_pkg::HIDDEN_Y;
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    sweep_next = AW'(sweep_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            sweep_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg  <= pend_kind_next;
        pend_rd_reg    <= pend_rd_next;
        pend_count_reg <= pend_count_next;
    end

    // y byte and remaining bytes kept apart so hide touches only y
    stw_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SPRITES)
    ) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .addr  (ram_addr),
        .wdata (y_wdata),
        .rdata (y_rdata)
    );

    stw_ram #(
        .WIDTH (24),
        .DEPTH (MAX_SPRITES)
    ) u_rest_ram (
        .clk   (clk),
        .we    (r_we),
        .addr  (ram_addr),
        .wdata (r_wdata),
        .rdata (r_rdata)
    );

    // assemble result from ram data
    always_comb
    begin
        res_in.kind  = pend_kind_reg;
        res_in.y     = pend_rd_reg ? y_rdata : '0;
        res_in.tile  = pend_rd_reg ? r_rdata[7:0] : '0;
        res_in.attr  = pend_rd_reg ? r_rdata[15:8] : '0;
        res_in.x     = pend_rd_reg ? r_rdata[23:16] : '0;
        res_in.count = pend_count_reg;
    end

    // result queue control
    assign empty  = rq_cnt_reg == '0;
    assign rq_pop = pop && !empty;
    assign res    = rq_reg[rq_rd_reg];

    always_comb
    begin
        rq_wr_next  = rq_wr_reg;
        rq_rd_next  = rq_rd_reg;
        rq_cnt_next = rq_cnt_reg;
        if (pend_valid_reg)
        begin
            rq_wr_next = (rq_wr_reg == RLAST) ? '0 : RPW'(rq_wr_reg + 1'b1);
        end
        if (rq_pop)
        begin
            rq_rd_next = (rq_rd_reg == RLAST) ? '0 : RPW'(rq_rd_reg + 1'b1);
        end
        if (pend_valid_reg && !rq_pop)
        begin
            rq_cnt_next = RCW'(rq_cnt_reg + 1'b1);
        end
        else if (rq_pop && !pend_valid_reg)
        begin
            rq_cnt_next = RCW'(rq_cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= '0;
            rq_rd_reg  <= '0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            rq_wr_reg  <= rq_wr_next;
            rq_rd_reg  <= rq_rd_next;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_reg)
        begin
            rq_reg[rq_wr_reg] <= res_in;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sprite_table_writer_top.sv
// path: a read or group-end request goes through the operation queue, the pending stage
//   with the table read and the result queue before its result shows
// throughput: one request per cycle while full is low; reads and group ends wait until
//   the result queue has room for them and the pending result; hide all holds the table
//   while the y memory is swept, the 2-entry request queue absorbs what follows
// reset: queues, group state and sequencer clear at once; table contents are undefined
`default_nettype none

module sprite_table_writer_top #(
    parameter int MAX_SPRITES = stw_pkg::MAX_SPRITES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [stw_pkg::CMD_W-1:0]   cmd,
    input  wire logic [5:0]                  slot,
    input  wire logic [15:0]                 pos_x,
    input  wire logic [15:0]                 pos_y,
    input  wire logic [7:0]                  tile,
    input  wire logic [7:0]                  attr,
    input  wire logic signed [7:0]           offset_x,
    input  wire logic signed [7:0]           offset_y,
    input  wire logic [7:0]                  attr_xor,
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             kind,
    output logic [7:0]                       entry_y,
    output logic [7:0]                       entry_tile,
    output logic [7:0]                       entry_attr,
    output logic [7:0]                       entry_x,
    output logic [6:0]                       placed_count
);

    logic           op_push;
    stw_pkg::op_t   op_in;
    stw_pkg::op_t   op_out;
    logic           op_empty;
    logic           op_pop;
    stw_pkg::res_t  res;

    // request decode and group state
    stw_front #(
        .MAX_SPRITES (MAX_SPRITES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .slot     (slot),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .tile     (tile),
        .attr     (attr),
        .offset_x (offset_x),
        .offset_y (offset_y),
        .attr_xor (attr_xor),
        .op_push  (op_push),
        .op       (op_in)
    );

    // operation queue between front and back
    stw_op_fifo u_op_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .din   (op_in),
        .full  (full),
        .pop   (op_pop),
        .dout  (op_out),
        .empty (op_empty)
    );

    // table access and results
    stw_back #(
        .MAX_SPRITES (MAX_SPRITES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op       (op_out),
        .op_pop   (op_pop),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

    assign kind         = res.kind;
    assign entry_y      = res.y;
    assign entry_tile   = res.tile;
    assign entry_attr   = res.attr;
    assign entry_x      = res.x;
    assign placed_count = res.count;

endmodule

`default_nettype wire

// File: hw/rtl/stw_checker.sv
`default_nettype none

module stw_checker #(
    parameter int MAX_SPRITES = stw_pkg::MAX_SPRITES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        empty,
    input  wire logic                        pop,
    input  wire logic                        kind,
    input  wire logic [7:0]                  entry_y,
    input  wire logic [7:0]                  entry_tile,
    input  wire logic [7:0]                  entry_attr,
    input  wire logic [7:0]                  entry_x,
    input  wire logic [6:0]                  placed_count
);

    // a waiting result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(kind) && $stable(placed_count))
        else $error("result changed before pop");

    // read-back results carry no count
    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == stw_pkg::KIND_ENTRY |-> placed_count == 7'd0)
        else $error("read result with nonzero count");

    // group reports carry no entry bytes
    a_group_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == stw_pkg::KIND_GROUP |->
        entry_y == 8'd0 && entry_tile == 8'd0 && entry_attr == 8'd0 && entry_x == 8'd0)
        else $error("group report with entry bytes");

    // a group never places more sprites than the table holds
    a_group_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == stw_pkg::KIND_GROUP |-> placed_count <= 7'(MAX_SPRITES))
        else $error("group count beyond table size");

endmodule

bind sprite_table_writer_top stw_checker #(
    .MAX_SPRITES (MAX_SPRITES)
) u_stw_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SPRITES    = stw_pkg::MAX_SPRITES_DEF;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_NS     = 2_000_000;

    // request codes the block ignores
    localparam logic [stw_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [stw_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [stw_pkg::CMD_W-1:0] cmd;
        logic [5:0]       slot;
        logic [15:0]      pos_x;
        logic [15:0]      pos_y;
        logic [7:0]       tile;
        logic [7:0]       attr;
        logic [7:0]       off_x;
        logic [7:0]       off_y;
        logic [7:0]       attr_xor;
    } sprite_req_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       y;
        logic [7:0]       tile;
        logic [7:0]       attr;
        logic [7:0]       x;
        logic [6:0]       count;
    } sprite_res_t;

    // shadow table, group state and the results still owed by the block
    class sprite_scoreboard;
        bit [7:0]    y_mem    [stw_pkg::TABLE_DEPTH];
        bit [7:0]    tile_mem [stw_pkg::TABLE_DEPTH];
        bit [7:0]    attr_mem [stw_pkg::TABLE_DEPTH];
        bit [7:0]    x_mem    [stw_pkg::TABLE_DEPTH];
        bit          filled   [stw_pkg::TABLE_DEPTH];
        bit [6:0]    grp_slot;
        bit [6:0]    grp_start;
        bit [15:0]   grp_x;
        bit [15:0]   grp_y;
        bit [7:0]    grp_attr;
        sprite_res_t expected_q [$];
        int          errors;

        // generic attribute bits to packed hardware layout
        function bit [7:0] hw_attr(bit [7:0] a);
            bit [7:0] r;
            r      = 8'h00;
            r[7]   = a[1];
            r[6]   = a[0];
            r[5]   = a[2];
            r[1:0] = a[5:4];
            return r;
        endfunction

        // y byte is stored one line above the pixel row
        function void place(int idx, bit [7:0] px, bit [7:0] py, bit [7:0] t, bit [7:0] a);
            if (idx >= N_SPRITES)
            begin
                return;
            end
            y_mem[idx]    = py - 8'd1;
            tile_mem[idx] = t;
            attr_mem[idx] = a;
            x_mem[idx]    = px;
            filled[idx]   = 1'b1;
        endfunction

        function void note_request(sprite_req_t r);
            sprite_res_t res;
            res = '0;
            case (r.cmd)
                stw_pkg::CMD_SET:
                    place(r.slot, r.pos_x[15:8], r.pos_y[15:8], r.tile, hw_attr(r.attr));
                stw_pkg::CMD_HIDE:
                    if (r.slot < N_SPRITES) y_mem[r.slot] = stw_pkg::HIDDEN_Y;
                stw_pkg::CMD_HIDE_ALL:
                    for (int i = 0; i < N_SPRITES; i++) y_mem[i] = stw_pkg::HIDDEN_Y;
                stw_pkg::CMD_GRP_BEGIN:
                begin
                    grp_start = {1'b0, r.slot};
                    grp_slot  = {1'b0, r.slot};
                    grp_x     = r.pos_x;
                    grp_y     = r.pos_y;
                    grp_attr  = r.attr;
                end
                stw_pkg::CMD_GRP_ENTRY:
                begin
                    // end marker reports, group state stays as it is
                    if (r.off_x == stw_pkg::END_MARK)
                    begin
                        res.kind  = stw_pkg::KIND_GROUP;
                        res.count = grp_slot - grp_start;
                        expected_q.push_back(res);
                    end
                    else if (grp_slot < N_SPRITES)
                    begin
                        place(grp_slot, grp_x[15:8] + r.off_x, grp_y[15:8] + r.off_y,
                              r.tile, hw_attr(grp_attr ^ r.attr_xor));
                        grp_slot = grp_slot + 7'd1;
                    end
                end
                stw_pkg::CMD_READ:
                begin
                    res.kind = stw_pkg::KIND_ENTRY;
                    if (r.slot < N_SPRITES)
                    begin
                        res.y    = y_mem[r.slot];
                        res.tile = tile_mem[r.slot];
                        res.attr = attr_mem[r.slot];
                        res.x    = x_mem[r.slot];
                    end
                    expected_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void cmp(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sprite_res_t got);
            sprite_res_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            cmp("kind", 8'(want.kind), 8'(got.kind));
            cmp("entry_y", want.y, got.y);
            cmp("entry_tile", want.tile, got.tile);
            cmp("entry_attr", want.attr, got.attr);
            cmp("entry_x", want.x, got.x);
            cmp("placed_count", 8'(want.count), 8'(got.count));
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n    = 1'b0;
    logic                         push     = 1'b0;
    logic [stw_pkg::CMD_W-1:0]    cmd      = '0;
    logic [5:0]                   slot     = '0;
    logic [15:0]                  pos_x    = '0;
    logic [15:0]                  pos_y    = '0;
    logic [7:0]                   tile     = '0;
    logic [7:0]                   attr     = '0;
    logic signed [7:0]            offset_x = '0;
    logic signed [7:0]            offset_y = '0;
    logic [7:0]                   attr_xor = '0;
    logic                         pop      = 1'b0;
    logic                         full;
    logic                         empty;
    logic                         kind;
    logic [7:0]                   entry_y;
    logic [7:0]                   entry_tile;
    logic [7:0]                   entry_attr;
    logic [7:0]                   entry_x;
    logic [6:0]                   placed_count;

    int                  push_idle_pct = 28;
    int                  pop_idle_pct  = 68;
    int                  n_sent        = 0;
    sprite_scoreboard    sb;

    sprite_table_writer_top #(
        .MAX_SPRITES (N_SPRITES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .tile         (tile),
        .attr         (attr),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .attr_xor     (attr_xor),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .entry_y      (entry_y),
        .entry_tile   (entry_tile),
        .entry_attr   (entry_attr),
        .entry_x      (entry_x),
        .placed_count (placed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #LIMIT_NS;
        $display("FAIL");
        $finish;
    end

    function automatic sprite_req_t make_req(logic [stw_pkg::CMD_W-1:0] c, logic [5:0] s,
                                             logic [15:0] px, logic [15:0] py,
                                             logic [7:0] t, logic [7:0] a,
                                             logic [7:0] ox, logic [7:0] oy,
                                             logic [7:0] m);
        sprite_req_t r;
        r.cmd      = c;
        r.slot     = s;
        r.pos_x    = px;
        r.pos_y    = py;
        r.tile     = t;
        r.attr     = a;
        r.off_x    = ox;
        r.off_y    = oy;
        r.attr_xor = m;
        return r;
    endfunction

    function automatic sprite_req_t rand_req(logic [stw_pkg::CMD_W-1:0] c);
        return make_req(c, 6'($urandom_range(63)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    // one request through push/full, with random gaps in front of it
    task automatic send(input sprite_req_t r);
        if ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < push_idle_pct);
        end
        push     <= 1'b1;
        cmd      <= r.cmd;
        slot     <= r.slot;
        pos_x    <= r.pos_x;
        pos_y    <= r.pos_y;
        tile     <= r.tile;
        attr     <= r.attr;
        offset_x <= r.off_x;
        offset_y <= r.off_y;
        attr_xor <= r.attr_xor;
        do @(posedge clk); while (full);
        sb.note_request(r);
        if (r.cmd != CMD_SPARE_6 && r.cmd != CMD_SPARE_7)
        begin
            n_sent++;
        end
    endtask

    // result side: take and check, then decide pop for the next edge
    initial
    begin
        sprite_res_t got;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.kind  = kind;
                got.y     = entry_y;
                got.tile  = entry_tile;
                got.attr  = entry_attr;
                got.x     = entry_x;
                got.count = placed_count;
                sb.check_result(got);
            end
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    // stimulus
    initial
    begin
        sprite_req_t r;
        int          n;
        int          pick;
        int          target;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // group entry straight after reset uses the reset group state
        send(make_req(stw_pkg::CMD_GRP_ENTRY, 6'd9, 16'h0000, 16'h0000, 8'h11, 8'h00, 8'h05,
                      8'h00, 8'hFF));
        send(make_req(stw_pkg::CMD_GRP_ENTRY, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00,
                      stw_pkg::END_MARK, 8'h00, 8'h00));
        send(make_req(stw_pkg::CMD_READ, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        // field extremes, y wraps below zero
        send(make_req(stw_pkg::CMD_SET, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        send(make_req(stw_pkg::CMD_SET, 6'd63, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF));
        send(make_req(stw_pkg::CMD_READ, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        send(make_req(stw_pkg::CMD_READ, 6'd63, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF));
        // unused attribute bits, hide keeps the other bytes
        send(make_req(stw_pkg::CMD_SET, 6'd5, 16'h7F80, 16'h0100, 8'hA5, 8'hCF, 8'h00, 8'h00,
                      8'h00));
        send(make_req(stw_pkg::CMD_HIDE, 6'd5, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        send(make_req(stw_pkg::CMD_READ, 6'd5, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        send(make_req(stw_pkg::CMD_HIDE, 6'd10, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        // group near the table end: wrap, overflow, repeated end marker
        send(make_req(stw_pkg::CMD_GRP_BEGIN, 6'd61, 16'h1080, 16'h0240, 8'h00, 8'h15, 8'h00,
                      8'h00, 8'h00));
        send(make_req(stw_pkg::CMD_GRP_ENTRY, 6'd0, 16'h0000, 16'h0000, 8'h3C, 8'h00, 8'h7F,
                      8'h81, 8'h00));
        send(make_req(stw_pkg::CMD_GRP_ENTRY, 6'd0, 16'h0000, 16'h0000, 8'h3D, 8'h00, 8'hFF,
                      8'h7F, 8'h3F));
        send(make_req(stw_pkg::CMD_GRP_ENTRY, 6'd0, 16'h0000, 16'h0000, 8'h3E, 8'h00, 8'h00,
                      8'h80, 8'hC8));
        send(make_req(stw_pkg::CMD_GRP_ENTRY, 6'd0, 16'h0000, 16'h0000, 8'h3F, 8'h00, 8'h01,
                      8'h01, 8'h01));
        send(make_req(stw_pkg::CMD_GRP_ENTRY, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00,
                      stw_pkg::END_MARK, 8'h00, 8'h00));
        send(make_req(stw_pkg::CMD_GRP_ENTRY, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00,
                      stw_pkg::END_MARK, 8'hFF, 8'hFF));
        send(make_req(stw_pkg::CMD_READ, 6'd61, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        send(make_req(stw_pkg::CMD_READ, 6'd63, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        // sweep, then the ignored codes
        send(make_req(stw_pkg::CMD_HIDE_ALL, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00));
        send(make_req(stw_pkg::CMD_READ, 6'd62, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));
        send(make_req(CMD_SPARE_6, 6'd63, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send(make_req(CMD_SPARE_7, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send(make_req(stw_pkg::CMD_READ, 6'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00));

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            push_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 68 : 0;
            pop_idle_pct  = (ph == 0) ? 68 : (ph == 1) ? 28 : 0;
            target        = n_sent + RANDOM_ITEMS / 3;
            while (n_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    // well-formed group, sometimes long enough to overflow
                    r = rand_req(stw_pkg::CMD_GRP_BEGIN);
                    if ($urandom_range(3) == 0) r.slot = 6'($urandom_range(50, 63));
                    send(r);
                    n = ($urandom_range(19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
                    repeat (n)
                    begin
                        r = rand_req(stw_pkg::CMD_GRP_ENTRY);
                        if (r.off_x == stw_pkg::END_MARK) r.off_x = 8'($urandom_range(127));
                        send(r);
                    end
                    // a few groups are left open
                    if ($urandom_range(9) != 0)
                    begin
                        r = rand_req(stw_pkg::CMD_GRP_ENTRY);
                        r.off_x = stw_pkg::END_MARK;
                        send(r);
                    end
                end
                else if (pick < 55)
                begin
                    send(rand_req(stw_pkg::CMD_SET));
                end
                else if (pick < 72 || pick >= 94)
                begin
                    // only entries whose four bytes were written are read
                    r = rand_req(stw_pkg::CMD_READ);
                    do r.slot = 6'($urandom_range(63)); while (!sb.filled[r.slot]);
                    send(r);
                end
                else if (pick < 82)
                begin
                    send(rand_req(stw_pkg::CMD_HIDE));
                end
                else if (pick < 84)
                begin
                    send(rand_req(stw_pkg::CMD_HIDE_ALL));
                end
                else if (pick < 90)
                begin
                    // stray group entry or end marker outside a sequence
                    r = rand_req(stw_pkg::CMD_GRP_ENTRY);
                    if ($urandom_range(1) == 0) r.off_x = stw_pkg::END_MARK;
                    send(r);
                end
                else
                begin
                    send(rand_req($urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6));
                end
            end
        end

        // drain
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
